// File: hdl/ltbc_pkg.sv
// Shared types and constants for the light transform and bounds cull block.
// Standalone package; no dependencies.
package ltbc_pkg;

    localparam int CoordW   = 20;
    localparam int DiffW    = CoordW + 1;
    localparam int AxisW    = 16;
    localparam int AxisFrac = 14;
    localparam int ProdW    = DiffW + AxisW;
    localparam int SumW     = ProdW + 2;
    localparam int LocW     = SumW - AxisFrac;
    localparam int LocalW   = 23;
    localparam int RadW     = 19;
    localparam int CmpW     = LocW + 2;
    localparam int MaskW    = 32;
    localparam int CountW   = 6;
    localparam int MaxLights = 32;
    localparam int VecW     = 3 * CoordW;
    localparam int RowW     = 3 * AxisW;
    localparam int DataW    = 64;
    localparam int AddrW    = 6;

    localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

    typedef logic signed [CoordW-1:0] coord_t;
    typedef logic signed [LocalW-1:0] local_t;
    typedef logic [RadW-1:0]          radius_t;
    typedef logic [MaskW-1:0]         mask_t;
    typedef logic [DataW-1:0]         apb_data_t;
    typedef logic [AddrW-1:0]         apb_addr_t;

    typedef enum logic [2:0] {
        REG_MODEL_ORIGIN = 3'd0,
        REG_AXIS_ROW0    = 3'd1,
        REG_AXIS_ROW1    = 3'd2,
        REG_AXIS_ROW2    = 3'd3,
        REG_BOX_MIN      = 3'd4,
        REG_BOX_MAX      = 3'd5
    } reg_index_t;

endpackage

// File: hdl/light_transform_bounds_cull.sv
// Top level of the point light transform and model box range test.
// Depends on ltbc_pkg for widths, types and register indexes.
//
// One light word is taken per clock while in_ready is high, and each light passes
// through the block's registers in turn: an input register, a register after the nine
// axis multiplies, and the result register where the box compares and the per-set hit
// mask are resolved. Throughput is one word per cycle while out_ready stays high; each
// stage holds only when the stage after it is full and stalled. Configuration
// registers sit on a 64-bit APB port at byte address 8*index.
module light_transform_bounds_cull (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  ltbc_pkg::apb_addr_t     paddr,
    input  ltbc_pkg::apb_data_t     pwdata,
    output ltbc_pkg::apb_data_t     prdata,
    output logic                    pready,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  ltbc_pkg::coord_t        light_x,
    input  ltbc_pkg::coord_t        light_y,
    input  ltbc_pkg::coord_t        light_z,
    input  ltbc_pkg::radius_t       light_radius,
    input  logic                    is_last,
    output logic                    out_valid,
    input  logic                    out_ready,
    output ltbc_pkg::local_t        local_x,
    output ltbc_pkg::local_t        local_y,
    output ltbc_pkg::local_t        local_z,
    output logic                    in_range,
    output ltbc_pkg::mask_t         light_mask,
    output logic                    any_light,
    output logic                    end_of_set
);
    import ltbc_pkg::*;

    // configuration
    logic [VecW-1:0]          origin_reg;
    logic [2:0][RowW-1:0]     axis_reg;
    logic [VecW-1:0]          box_min_reg;
    logic [VecW-1:0]          box_max_reg;
    logic                     cfg_wr;
    reg_index_t               cfg_idx;

    // pipeline control
    logic                     s1_valid_reg;
    logic                     s2_valid_reg;
    logic                     o_valid_reg;
    logic                     s1_en;
    logic                     s2_en;
    logic                     o_en;

    // stage payloads
    logic [2:0][CoordW-1:0]   s1_pos_reg;
    radius_t                  s1_rad_reg;
    logic                     s1_last_reg;
    logic signed [ProdW-1:0]  prod_next [3][3];
    logic signed [ProdW-1:0]  prod_reg  [3][3];
    radius_t                  s2_rad_reg;
    logic                     s2_last_reg;
    logic signed [DiffW-1:0]  diff [3];

    // result stage
    logic signed [SumW-1:0]   sum [3];
    logic signed [LocW-1:0]   loc [3];
    local_t                   sat [3];
    logic                     hit;
    logic                     bit_ok;
    mask_t                    mask_set;
    logic [CountW-1:0]        count_reg;
    logic [CountW-1:0]        count_next;
    mask_t                    hit_mask_reg;
    mask_t                    hit_mask_next;
    local_t                   lx_reg;
    local_t                   ly_reg;
    local_t                   lz_reg;
    logic                     range_reg;
    mask_t                    mask_out_reg;
    logic                     any_reg;
    logic                     eos_reg;

    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_index_t'(paddr[AddrW-1:3]);
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_reg  <= '0;
            axis_reg    <= '0;
            box_min_reg <= '0;
            box_max_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_MODEL_ORIGIN: origin_reg  <= pwdata[VecW-1:0];
                REG_AXIS_ROW0:    axis_reg[0] <= pwdata[RowW-1:0];
                REG_AXIS_ROW1:    axis_reg[1] <= pwdata[RowW-1:0];
                REG_AXIS_ROW2:    axis_reg[2] <= pwdata[RowW-1:0];
                REG_BOX_MIN:      box_min_reg <= pwdata[VecW-1:0];
                REG_BOX_MAX:      box_max_reg <= pwdata[VecW-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_MODEL_ORIGIN: prdata = {{(DataW-VecW){1'b0}}, origin_reg};
            REG_AXIS_ROW0:    prdata = {{(DataW-RowW){1'b0}}, axis_reg[0]};
            REG_AXIS_ROW1:    prdata = {{(DataW-RowW){1'b0}}, axis_reg[1]};
            REG_AXIS_ROW2:    prdata = {{(DataW-RowW){1'b0}}, axis_reg[2]};
            REG_BOX_MIN:      prdata = {{(DataW-VecW){1'b0}}, box_min_reg};
            REG_BOX_MAX:      prdata = {{(DataW-VecW){1'b0}}, box_max_reg};
            default:          prdata = '0;
        endcase
    end

    // advance each stage when the one after it has room
    assign o_en     = !o_valid_reg || out_ready;
    assign s2_en    = !s2_valid_reg || o_en;
    assign s1_en    = !s1_valid_reg || s2_en;
    assign in_ready = s1_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
            count_reg    <= '0;
            hit_mask_reg <= '0;
        end
        else
        begin
            if (s1_en)
                s1_valid_reg <= in_valid;
            if (s2_en)
                s2_valid_reg <= s1_valid_reg;
            if (o_en)
                o_valid_reg <= s2_valid_reg;
            if (o_en && s2_valid_reg)
            begin
                count_reg    <= count_next;
                hit_mask_reg <= hit_mask_next;
            end
        end
    end

    // stage 1 to 2: subtract origin, nine axis products
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            diff[i] = $signed({s1_pos_reg[i][CoordW-1], s1_pos_reg[i]})
                    - $signed({origin_reg[CoordW*i+CoordW-1], origin_reg[CoordW*i +: CoordW]});
        end
        for (int k = 0; k < 3; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                prod_next[k][i] = diff[i] * $signed(axis_reg[k][AxisW*i +: AxisW]);
            end
        end
    end

    // stage 2 to result: round, saturate, box test, mask
    always_comb
    begin
        hit = 1'b1;
        for (int k = 0; k < 3; k++)
        begin
            sum[k] = SumW'(prod_reg[k][0]) + SumW'(prod_reg[k][1]) + SumW'(prod_reg[k][2])
                   + SumW'(1 << (AxisFrac - 1));
            loc[k] = sum[k][SumW-1:AxisFrac];
            if (loc[k][LocW-1:LocalW-1] == '0 || loc[k][LocW-1:LocalW-1] == '1)
                sat[k] = loc[k][LocalW-1:0];
            else if (loc[k][LocW-1])
                sat[k] = {1'b1, {(LocalW-1){1'b0}}};
            else
                sat[k] = {1'b0, {(LocalW-1){1'b1}}};
            if (CmpW'(loc[k]) - CmpW'($signed(box_max_reg[CoordW*k +: CoordW]))
                > $signed({{(CmpW-RadW){1'b0}}, s2_rad_reg}))
                hit = 1'b0;
            if (CmpW'($signed(box_min_reg[CoordW*k +: CoordW])) - CmpW'(loc[k])
                > $signed({{(CmpW-RadW){1'b0}}, s2_rad_reg}))
                hit = 1'b0;
        end
        bit_ok   = hit && (count_reg < CountW'(MaskW)) && (count_reg < CountW'(MaxLights));
        mask_set = hit_mask_reg;
        if (bit_ok)
            mask_set[count_reg[$clog2(MaskW)-1:0]] = 1'b1;
        if (s2_last_reg)
        begin
            count_next    = '0;
            hit_mask_next = '0;
        end
        else
        begin
            count_next    = (count_reg == CountMax) ? count_reg : count_reg + 1'b1;
            hit_mask_next = mask_set;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en && in_valid)
        begin
            s1_pos_reg[0] <= light_x;
            s1_pos_reg[1] <= light_y;
            s1_pos_reg[2] <= light_z;
            s1_rad_reg    <= light_radius;
            s1_last_reg   <= is_last;
        end
        if (s2_en && s1_valid_reg)
        begin
            prod_reg    <= prod_next;
            s2_rad_reg  <= s1_rad_reg;
            s2_last_reg <= s1_last_reg;
        end
        if (o_en && s2_valid_reg)
        begin
            lx_reg       <= sat[0];
            ly_reg       <= sat[1];
            lz_reg       <= sat[2];
            range_reg    <= hit;
            mask_out_reg <= s2_last_reg ? mask_set : '0;
            any_reg      <= s2_last_reg && (mask_set != '0);
            eos_reg      <= s2_last_reg;
        end
    end

    assign out_valid  = o_valid_reg;
    assign local_x    = lx_reg;
    assign local_y    = ly_reg;
    assign local_z    = lz_reg;
    assign in_range   = range_reg;
    assign light_mask = mask_out_reg;
    assign any_light  = any_reg;
    assign end_of_set = eos_reg;

    // no mask bit at or above the running light count
    a_mask_below_count: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg < CountW'(MaskW)) |-> ((hit_mask_reg >> count_reg) == '0))
        else $error("hit mask bit set beyond light count");

    // closing a set clears the set state
    a_set_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (o_en && s2_valid_reg && s2_last_reg) |=> (count_reg == '0 && hit_mask_reg == '0))
        else $error("set state not cleared after last light");

    // mask and flag only report on the last light
    a_mid_set_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !end_of_set) |-> (light_mask == '0 && !any_light))
        else $error("mask reported mid set");

    // any_light follows the reported mask
    a_any_matches: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (any_light == (light_mask != '0)))
        else $error("any_light disagrees with light_mask");

endmodule

// File: verif/tb_light_transform_bounds_cull.sv
// Testbench for light_transform_bounds_cull: directed and random point lights checked
// against an in-bench model of the transform, box test and per-set hit mask.
// Depends on ltbc_pkg and the light_transform_bounds_cull RTL only.
`timescale 1ns / 1ps

module tb_light_transform_bounds_cull;
    import ltbc_pkg::*;

    typedef struct packed {
        local_t lx;
        local_t ly;
        local_t lz;
        logic   hit;
        mask_t  mask;
        logic   any;
        logic   last;
    } light_result_t;

    logic      clk;
    logic      rst_n;
    logic      psel;
    logic      penable;
    logic      pwrite;
    apb_addr_t paddr;
    apb_data_t pwdata;
    apb_data_t prdata;
    logic      pready;
    logic      in_valid;
    logic      in_ready;
    coord_t    light_x;
    coord_t    light_y;
    coord_t    light_z;
    radius_t   light_radius;
    logic      is_last;
    logic      out_valid;
    logic      out_ready;
    local_t    local_x;
    local_t    local_y;
    local_t    local_z;
    logic      in_range;
    mask_t     light_mask;
    logic      any_light;
    logic      end_of_set;

    logic [63:0]       cfg_shadow [6];
    logic [CountW-1:0] set_count;
    mask_t             set_hits;
    light_result_t     expected_lights [$];
    int                errors;
    int                hold_left;
    int                stall_left;
    bit                send_gaps;
    bit                sink_stalls;

    light_transform_bounds_cull dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .light_x      (light_x),
        .light_y      (light_y),
        .light_z      (light_z),
        .light_radius (light_radius),
        .is_last      (is_last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .local_x      (local_x),
        .local_y      (local_y),
        .local_z      (local_z),
        .in_range     (in_range),
        .light_mask   (light_mask),
        .any_light    (any_light),
        .end_of_set   (end_of_set)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("light_transform_bounds_cull test failed");
        $finish;
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    function automatic int rs(int n);
        return int'($urandom_range(0, 2 * n)) - n;
    endfunction

    function automatic logic [63:0] pack_coords(int a, int b, int c);
        return {4'b0, c[19:0], b[19:0], a[19:0]};
    endfunction

    function automatic logic [63:0] pack_axes(int a, int b, int c);
        return {16'b0, c[15:0], b[15:0], a[15:0]};
    endfunction

    function automatic logic [63:0] reg_mask(reg_index_t idx);
        if (idx == REG_AXIS_ROW0 || idx == REG_AXIS_ROW1 || idx == REG_AXIS_ROW2)
            return {16'b0, {48{1'b1}}};
        return {4'b0, {60{1'b1}}};
    endfunction

    function automatic longint coord_of(logic [63:0] v, int k);
        coord_t c;
        c = v[k*CoordW +: CoordW];
        return longint'(c);
    endfunction

    function automatic longint axis_of(logic [63:0] v, int k);
        logic signed [AxisW-1:0] a;
        a = v[k*AxisW +: AxisW];
        return longint'(a);
    endfunction

    // Transform one light, run the box test and advance the set mask.
    function automatic light_result_t cull_light(coord_t x, coord_t y, coord_t z,
                                                 radius_t r, logic last);
        longint        d [3];
        longint        loc [3];
        longint        s;
        longint        sat;
        longint        rad;
        logic          hit;
        light_result_t res;
        d[0] = longint'(x) - coord_of(cfg_shadow[REG_MODEL_ORIGIN], 0);
        d[1] = longint'(y) - coord_of(cfg_shadow[REG_MODEL_ORIGIN], 1);
        d[2] = longint'(z) - coord_of(cfg_shadow[REG_MODEL_ORIGIN], 2);
        rad = longint'(r);
        hit = 1'b1;
        for (int k = 0; k < 3; k++)
        begin
            s = 0;
            for (int i = 0; i < 3; i++)
                s += d[i] * axis_of(cfg_shadow[int'(REG_AXIS_ROW0) + k], i);
            loc[k] = (s + (64'sd1 <<< (AxisFrac - 1))) >>> AxisFrac;
            if (loc[k] - coord_of(cfg_shadow[REG_BOX_MAX], k) > rad)
                hit = 1'b0;
            if (coord_of(cfg_shadow[REG_BOX_MIN], k) - loc[k] > rad)
                hit = 1'b0;
        end
        for (int k = 0; k < 3; k++)
        begin
            sat = loc[k];
            if (sat > 64'sd4194303)
                sat = 64'sd4194303;
            if (sat < -64'sd4194304)
                sat = -64'sd4194304;
            if (k == 0)
                res.lx = local_t'(sat);
            else if (k == 1)
                res.ly = local_t'(sat);
            else
                res.lz = local_t'(sat);
        end
        if (hit && set_count < MaskW && set_count < MaxLights)
            set_hits[set_count[4:0]] = 1'b1;
        if (set_count != CountMax)
            set_count = set_count + 1'b1;
        res.hit = hit;
        res.last = last;
        res.mask = last ? set_hits : '0;
        res.any = last ? |set_hits : 1'b0;
        if (last)
        begin
            set_count = '0;
            set_hits = '0;
        end
        return res;
    endfunction

    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_lights.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(reg_index_t idx, logic [63:0] val);
        @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {idx, 3'b000};
        pwdata = val;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        cfg_shadow[idx] = val & reg_mask(idx);
        @(negedge clk);
        pwrite = 1'b0;
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        if ((prdata & reg_mask(idx)) !== cfg_shadow[idx])
        begin
            $display("%0t: register %0d read exp %h got %h", $time, idx,
                     cfg_shadow[idx], prdata & reg_mask(idx));
            errors++;
        end
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    task automatic cfg_all(logic [63:0] origin, logic [63:0] row0, logic [63:0] row1,
                           logic [63:0] row2, logic [63:0] bmin, logic [63:0] bmax);
        wait_idle();
        cfg_write(REG_MODEL_ORIGIN, origin);
        cfg_write(REG_AXIS_ROW0, row0);
        cfg_write(REG_AXIS_ROW1, row1);
        cfg_write(REG_AXIS_ROW2, row2);
        cfg_write(REG_BOX_MIN, bmin);
        cfg_write(REG_BOX_MAX, bmax);
    endtask

    task automatic send_light(coord_t x, coord_t y, coord_t z, radius_t r, logic last);
        int gap;
        gap = (send_gaps && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        light_x = x;
        light_y = y;
        light_z = z;
        light_radius = r;
        is_last = last;
        do @(posedge clk); while (!in_ready);
        expected_lights.push_back(cull_light(x, y, z, r, last));
    endtask

    task automatic send_random_light(logic last);
        coord_t  x;
        coord_t  y;
        coord_t  z;
        radius_t r;
        if ($urandom_range(0, 9) < 6)
        begin
            x = coord_t'(rs(4096));
            y = coord_t'(rs(4096));
            z = coord_t'(rs(4096));
            r = radius_t'($urandom_range(0, 4096));
        end
        else
        begin
            x = coord_t'($urandom);
            y = coord_t'($urandom);
            z = coord_t'($urandom);
            r = radius_t'($urandom);
        end
        send_light(x, y, z, r, last);
    endtask

    task automatic send_random_set(int len);
        for (int i = 0; i < len; i++)
            send_random_light(i == len - 1);
    endtask

    // All registers still at zero: every light lands on the origin and is in range.
    task automatic test_reset_state();
        for (int i = 0; i < 6; i++)
            if (cfg_shadow[i] !== '0)
                errors++;
        send_light(coord_t'(524287), coord_t'(-524288), coord_t'(0), radius_t'(0), 1'b0);
        send_light(coord_t'(-1), coord_t'(1), coord_t'(-524288), radius_t'(524287), 1'b0);
        send_light(coord_t'(0), coord_t'(0), coord_t'(0), radius_t'(0), 1'b1);
    endtask

    task automatic test_box_edges();
        cfg_all(pack_coords(0, 0, 0), pack_axes(16384, 0, 0), pack_axes(0, 16384, 0),
                pack_axes(0, 0, 16384), pack_coords(-800, -800, -800),
                pack_coords(800, 800, 800));
        send_light(coord_t'(0), coord_t'(0), coord_t'(0), radius_t'(0), 1'b0);
        send_light(coord_t'(524287), coord_t'(524287), coord_t'(524287),
                   radius_t'(524287), 1'b0);
        send_light(coord_t'(-524288), coord_t'(-524288), coord_t'(-524288),
                   radius_t'(0), 1'b0);
        send_light(coord_t'(801), coord_t'(0), coord_t'(0), radius_t'(0), 1'b0);
        send_light(coord_t'(0), coord_t'(801), coord_t'(0), radius_t'(1), 1'b0);
        send_light(coord_t'(0), coord_t'(0), coord_t'(-801), radius_t'(1), 1'b0);
        send_light(coord_t'(-802), coord_t'(0), coord_t'(0), radius_t'(1), 1'b1);
    endtask

    task automatic test_rounding_saturation();
        cfg_all(pack_coords(0, 0, 0), pack_axes(1, 0, 0), pack_axes(0, 1, 0),
                pack_axes(0, 0, 1), pack_coords(-524288, -524288, -524288),
                pack_coords(524287, 524287, 524287));
        send_light(coord_t'(8192), coord_t'(8191), coord_t'(-8192), radius_t'(0), 1'b0);
        send_light(coord_t'(-8193), coord_t'(24576), coord_t'(-24577), radius_t'(0), 1'b1);
        cfg_all(pack_coords(524287, 524287, 524287),
                pack_axes(-32768, -32768, -32768), pack_axes(32767, 32767, 32767),
                pack_axes(-32768, 32767, 0), pack_coords(-524288, -524288, -524288),
                pack_coords(524287, 524287, 524287));
        send_light(coord_t'(-524288), coord_t'(-524288), coord_t'(-524288),
                   radius_t'(524287), 1'b0);
        wait_idle();
        cfg_write(REG_MODEL_ORIGIN, pack_coords(-524288, -524288, -524288));
        send_light(coord_t'(524287), coord_t'(524287), coord_t'(524287),
                   radius_t'(524287), 1'b1);
    endtask

    task automatic test_inverted_box();
        cfg_all(pack_coords(0, 0, 0), pack_axes(16384, 0, 0), pack_axes(0, 16384, 0),
                pack_axes(0, 0, 16384), pack_coords(100, 100, 100),
                pack_coords(-100, -100, -100));
        send_light(coord_t'(0), coord_t'(0), coord_t'(0), radius_t'(99), 1'b0);
        send_light(coord_t'(0), coord_t'(0), coord_t'(0), radius_t'(100), 1'b1);
    endtask

    // Sets longer than the mask and the light counter.
    task automatic test_long_sets();
        cfg_all(pack_coords(0, 0, 0), pack_axes(16384, 0, 0), pack_axes(0, 16384, 0),
                pack_axes(0, 0, 16384), pack_coords(-2000, -2000, -2000),
                pack_coords(2000, 2000, 2000));
        for (int i = 0; i < 70; i++)
            send_light(coord_t'(rs(4096)), coord_t'(rs(4096)), coord_t'(rs(4096)),
                       radius_t'(524287), i == 69);
        send_random_set(70);
    endtask

    task automatic test_backpressure();
        wait_idle();
        send_gaps = 1'b0;
        hold_left = 60;
        for (int i = 0; i < 40; i++)
            send_random_light($urandom_range(0, 7) == 0);
        wait_idle();
        send_gaps = 1'b1;
    endtask

    task automatic test_random_phase(int mode, int quota);
        logic [63:0] cfg [6];
        int          sent;
        int          len;
        int          lo;
        int          ax [3];
        int          bmin [3];
        int          bmax [3];
        case (mode)
            0:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    bmin[k] = rs(3000);
                    bmax[k] = bmin[k] + int'($urandom_range(0, 4000));
                end
                cfg[0] = pack_coords(rs(4000), rs(4000), rs(4000));
                for (int k = 0; k < 3; k++)
                begin
                    for (int i = 0; i < 3; i++)
                        ax[i] = (i == k) ? 16384 + rs(2000) : rs(3000);
                    cfg[1 + k] = pack_axes(ax[0], ax[1], ax[2]);
                end
                cfg[4] = pack_coords(bmin[0], bmin[1], bmin[2]);
                cfg[5] = pack_coords(bmax[0], bmax[1], bmax[2]);
            end
            1:
                for (int i = 0; i < 6; i++)
                    cfg[i] = {$urandom, $urandom};
            2:
                for (int i = 0; i < 6; i++)
                    cfg[i] = '1;
            default:
            begin
                for (int i = 0; i < 6; i++)
                begin
                    lo = 0;
                    for (int k = 0; k < 3; k++)
                        ax[k] = $urandom_range(0, 1) ? 1 : 0;
                    if (i >= 1 && i <= 3)
                        cfg[i] = pack_axes(ax[0] ? 32767 : -32768, ax[1] ? 32767 : -32768,
                                           ax[2] ? 32767 : -32768);
                    else
                        cfg[i] = pack_coords(ax[0] ? 524287 : -524288,
                                             ax[1] ? 524287 : -524288,
                                             ax[2] ? 524287 : lo);
                end
            end
        endcase
        cfg_all(cfg[0], cfg[1], cfg[2], cfg[3], cfg[4], cfg[5]);
        send_gaps = $urandom_range(0, 3) != 0;
        sink_stalls = $urandom_range(0, 3) != 0;
        sent = 0;
        while (sent < quota)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 70)
                                              : $urandom_range(1, 40);
            send_random_set(len);
            sent += len;
        end
        send_gaps = 1'b1;
        sink_stalls = 1'b1;
    endtask

    initial
    begin : sink_drive
        out_ready = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_ready = 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                out_ready = 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready = 1'b1;
                if (sink_stalls && $urandom_range(0, 99) < 25)
                    stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        light_result_t got;
        light_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got.lx = local_x;
            got.ly = local_y;
            got.lz = local_z;
            got.hit = in_range;
            got.mask = light_mask;
            got.any = any_light;
            got.last = end_of_set;
            if (expected_lights.size() == 0)
            begin
                $display("%0t: unexpected word x=%0d y=%0d z=%0d hit=%b mask=%h", $time,
                         got.lx, got.ly, got.lz, got.hit, got.mask);
                errors++;
            end
            else
            begin
                want = expected_lights.pop_front();
                if (got !== want)
                begin
                    $display("%0t: exp x=%0d y=%0d z=%0d hit=%b mask=%h any=%b last=%b",
                             $time, want.lx, want.ly, want.lz, want.hit, want.mask,
                             want.any, want.last);
                    $display("%0t: got x=%0d y=%0d z=%0d hit=%b mask=%h any=%b last=%b",
                             $time, got.lx, got.ly, got.lz, got.hit, got.mask,
                             got.any, got.last);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        errors = 0;
        hold_left = 0;
        send_gaps = 1'b1;
        sink_stalls = 1'b1;
        set_count = '0;
        set_hits = '0;
        for (int i = 0; i < 6; i++)
            cfg_shadow[i] = '0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        light_x = '0;
        light_y = '0;
        light_z = '0;
        light_radius = '0;
        is_last = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_box_edges();
        test_rounding_saturation();
        test_inverted_box();
        test_long_sets();
        test_backpressure();
        for (int p = 0; p < 8; p++)
            test_random_phase(p % 4, 170);
        test_backpressure();

        @(negedge clk);
        in_valid = 1'b0;
        while (expected_lights.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("light_transform_bounds_cull test passed");
        else
            $display("light_transform_bounds_cull test failed");
        $finish;
    end

endmodule

// File: light_transform_bounds_cull.f
hdl/ltbc_pkg.sv
hdl/light_transform_bounds_cull.sv
verif/tb_light_transform_bounds_cull.sv
